// ===== rtl/core/ehdp_pkg.sv =====
package ehdp_pkg;

	// fixed field widths
	localparam int TEMP_W     = 24;
	localparam int FLUX_W     = 20;
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	// shared multiplier: unsigned 32-bit operand times signed 34-bit operand
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 34;
	localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;

	// width of the signed sums that feed the saturation
	localparam int SUM_W = 48;

	// register indexes on the configuration port
	localparam logic [2:0] REG_DIFF_GAIN  = 3'd0;
	localparam logic [2:0] REG_SURF_GAIN  = 3'd1;
	localparam logic [2:0] REG_EMIS_COEFF = 3'd2;
	localparam logic [2:0] REG_ABSORP     = 3'd3;
	localparam logic [2:0] REG_ACTIVE     = 3'd4;

	typedef struct packed {
		logic [23:0] diff_gain;
		logic [23:0] surf_gain;
		logic [31:0] emis_coeff;
		logic [16:0] absorp;
		logic [10:0] active_slices;
	} cfg_t;

	// floor((v + 2^(sh-1)) / 2^sh), sh is a constant at every call
	function automatic logic signed [SUM_W-1:0] rnd_shift(input logic signed [PROD_W-1:0] v,
			input int unsigned sh);
		logic signed [PROD_W-1:0] half;
		logic signed [PROD_W-1:0] t;
		half = PROD_W'(1) <<< (sh - 1);
		t = (v + half) >>> sh;
		return t[SUM_W-1:0];
	endfunction

	// clamp to the unsigned temperature range
	function automatic logic [TEMP_W-1:0] sat_temp(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] top;
		top = SUM_W'((1 << TEMP_W) - 1);
		if (v < 0) begin
			return '0;
		end else if (v > top) begin
			return '1;
		end
		return v[TEMP_W-1:0];
	endfunction

endpackage

// ===== rtl/core/ehdp_ram.sv =====
module ehdp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/ehdp_regs.sv =====
module ehdp_regs
	import ehdp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	localparam logic [31:0] EMIS_RST   = 32'd14357596;
	localparam logic [16:0] ABSORP_RST = 17'd52429;
	localparam logic [10:0] ACTIVE_RST = 11'd1024;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[CFG_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diff_gain     <= '0;
			cfg_q.surf_gain     <= '0;
			cfg_q.emis_coeff    <= EMIS_RST;
			cfg_q.absorp        <= ABSORP_RST;
			cfg_q.active_slices <= ACTIVE_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DIFF_GAIN:  cfg_q.diff_gain     <= pwdata[23:0];
				REG_SURF_GAIN:  cfg_q.surf_gain     <= pwdata[23:0];
				REG_EMIS_COEFF: cfg_q.emis_coeff    <= pwdata;
				REG_ABSORP:     cfg_q.absorp        <= pwdata[16:0];
				REG_ACTIVE:     cfg_q.active_slices <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_DIFF_GAIN:  prdata = {8'b0, cfg_q.diff_gain};
			REG_SURF_GAIN:  prdata = {8'b0, cfg_q.surf_gain};
			REG_EMIS_COEFF: prdata = cfg_q.emis_coeff;
			REG_ABSORP:     prdata = {15'b0, cfg_q.absorp};
			REG_ACTIVE:     prdata = {21'b0, cfg_q.active_slices};
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/explicit_heat_diffusion_profile.sv =====
// One-dimensional column of temperatures (Q10.14 kelvin), slice 0 at the surface
// down to a fixed bottom slice n = active_slices clamped to [2, MAX_SLICES]. The
// user must write settings over the APB port only while idle; the block does not check.
// Item channel (item_valid / item_stall): func 0 fills every slice with
// temperature, func 1 advances one explicit time step using flux.
// Result channel (result_valid / result_stall): one word per item with the
// surface slice and slice n-1 after the item.
// Item work: a fill sweeps all MAX_SLICES+1 entries of the slice RAM, one
// per cycle. A step reads slices 0 and 1 and forms the surface term on the
// shared multiplier, then streams slices 1..n-1 through the same multiplier
// one per cycle. The single multiplier and the RAM write port set this pace.
// item_stall is high while an item is in work; a finished word sits in the
// output register, so the next item is taken while it waits. If the receiver
// still stalls when the next word is done, the sequencer holds until the
// output register frees.
// Reset clears the sequencer and the output valid and loads register
// defaults; slice contents are undefined until the first fill.
module explicit_heat_diffusion_profile
	import ehdp_pkg::*;
#(
	parameter int MAX_SLICES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  func,
	input  logic [TEMP_W-1:0]     temperature,
	input  logic [FLUX_W-1:0]     flux,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [TEMP_W-1:0]     surface_temp,
	output logic [TEMP_W-1:0]     deep_temp
);

	localparam int DEPTH = MAX_SLICES + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;

	typedef enum logic [14:0] {
		ST_IDLE   = 15'b000000000000001,
		ST_FILL   = 15'b000000000000010,
		ST_RD0    = 15'b000000000000100,
		ST_RD1    = 15'b000000000001000,
		ST_RD2    = 15'b000000000010000,
		ST_M1     = 15'b000000000100000,
		ST_M2     = 15'b000000001000000,
		ST_M3     = 15'b000000010000000,
		ST_M4     = 15'b000000100000000,
		ST_M5     = 15'b000001000000000,
		ST_M6     = 15'b000010000000000,
		ST_M7     = 15'b000100000000000,
		ST_STREAM = 15'b001000000000000,
		ST_DRAIN  = 15'b010000000000000,
		ST_DONE   = 15'b100000000000000
	} state_t;

	cfg_t   cfg;
	state_t state_q;

	logic              out_valid_q;
	logic              wr_s1;
	logic              accept;
	logic              out_free;

	// item payload and column bound
	logic [TEMP_W-1:0] temp_q;
	logic [FLUX_W-1:0] flux_q;
	logic [AW-1:0]     n_q;
	logic [AW-1:0]     n_clamp;
	logic [31:0]       n_ext;
	logic [31:0]       n_sel;

	// surface term
	logic [TEMP_W-1:0]        t0_q;
	logic [TEMP_W-1:0]        t1_q;
	logic signed [24:0]       dt_q;
	logic [27:0]              lo_q;
	logic [59:0]              acc_q;
	logic [32:0]              rad_q;
	logic signed [33:0]       net_q;
	logic signed [SUM_W-1:0]  cond_q;
	logic [60:0]              rad_sum;
	logic [TEMP_W-1:0]        new0;

	// interior stream
	logic [TEMP_W-1:0]  prev_q;
	logic [TEMP_W-1:0]  cur_q;
	logic [TEMP_W-1:0]  cur_s1;
	logic [AW-1:0]      k_s1;
	logic [AW-1:0]      kk_q;
	logic [CW-1:0]      ra_q;
	logic [AW-1:0]      fc_q;
	logic signed [26:0] d2;
	logic [TEMP_W-1:0]  new_k;

	// results
	logic [TEMP_W-1:0] surf_q;
	logic [TEMP_W-1:0] deep_q;
	logic [TEMP_W-1:0] out_surf_q;
	logic [TEMP_W-1:0] out_deep_q;

	// shared multiplier
	logic [MUL_A_W-1:0]        mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_A_W:0]   a_ext;
	logic signed [PROD_W-1:0]  prod_q;

	// RAM ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [TEMP_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [TEMP_W-1:0] rd_data;

	ehdp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ehdp_ram #(
		.WIDTH (TEMP_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && (state_q == ST_IDLE);
	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign surface_temp = out_surf_q;
	assign deep_temp    = out_deep_q;

	// bottom index clamped to [2, MAX_SLICES]
	always_comb begin
		n_ext = {21'b0, cfg.active_slices};
		if (n_ext < 32'd2) begin
			n_sel = 32'd2;
		end else if (n_ext > 32'(MAX_SLICES)) begin
			n_sel = 32'(MAX_SLICES);
		end else begin
			n_sel = n_ext;
		end
		n_clamp = n_sel[AW-1:0];
	end

	// radiation sum, surface result, interior second difference and interior result
	assign rad_sum = {1'b0, acc_q} + {29'b0, prod_q[59:28]};
	assign new0    = sat_temp($signed({24'b0, t0_q}) + cond_q - rnd_shift(prod_q, 14));
	assign d2      = $signed({3'b0, rd_data}) - $signed({2'b0, cur_q, 1'b0})
			+ $signed({3'b0, prev_q});
	assign new_k   = sat_temp($signed({24'b0, cur_s1}) + rnd_shift(prod_q, 24));

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_RD2: begin
				mul_a = {8'b0, t0_q};
				mul_b = {10'b0, t0_q};
			end
			ST_M1: begin
				mul_a = {4'b0, prod_q[47:20]};
				mul_b = {6'b0, prod_q[47:20]};
			end
			ST_M2: begin
				mul_a = cfg.emis_coeff;
				mul_b = {6'b0, prod_q[55:28]};
			end
			ST_M3: begin
				mul_a = cfg.emis_coeff;
				mul_b = {6'b0, lo_q};
			end
			ST_M4: begin
				mul_a = {15'b0, cfg.absorp};
				mul_b = {14'b0, flux_q};
			end
			ST_M5: begin
				mul_a = {8'b0, cfg.diff_gain};
				mul_b = {{8{dt_q[24]}}, dt_q, 1'b0};
			end
			ST_M6: begin
				mul_a = {8'b0, cfg.surf_gain};
				mul_b = net_q;
			end
			ST_STREAM: begin
				mul_a = {8'b0, cfg.diff_gain};
				mul_b = {{7{d2[26]}}, d2};
			end
			ST_IDLE, ST_FILL, ST_RD0, ST_RD1, ST_M7, ST_DRAIN, ST_DONE: ;
			default: ;
		endcase
	end

	assign a_ext = $signed({1'b0, mul_a});

	always_ff @(posedge clk) begin
		prod_q <= a_ext * mul_b;
	end

	// RAM write port: fill sweep, surface write, interior write-back
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = fc_q;
		ram_wdata = temp_q;
		priority if (state_q == ST_FILL) begin
			ram_we = 1'b1;
		end else if (state_q == ST_M7) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			ram_wdata = new0;
		end else if (wr_s1) begin
			ram_we    = 1'b1;
			ram_waddr = k_s1;
			ram_wdata = new_k;
		end
	end

	// RAM read port
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = ra_q[AW-1:0];
		unique case (state_q)
			ST_RD0: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			ST_RD1: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(1);
			end
			ST_M7: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(2);
			end
			ST_STREAM: begin
				ram_re = (ra_q <= {1'b0, n_q});
			end
			ST_IDLE, ST_FILL, ST_RD2, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
			ST_DRAIN, ST_DONE: ;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			wr_s1       <= 1'b0;
		end else begin
			wr_s1 <= (state_q == ST_STREAM);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= func ? ST_RD0 : ST_FILL;
					end
				end
				ST_FILL: begin
					if (fc_q == AW'(MAX_SLICES)) begin
						state_q <= ST_DONE;
					end
				end
				ST_RD0:    state_q <= ST_RD1;
				ST_RD1:    state_q <= ST_RD2;
				ST_RD2:    state_q <= ST_M1;
				ST_M1:     state_q <= ST_M2;
				ST_M2:     state_q <= ST_M3;
				ST_M3:     state_q <= ST_M4;
				ST_M4:     state_q <= ST_M5;
				ST_M5:     state_q <= ST_M6;
				ST_M6:     state_q <= ST_M7;
				ST_M7:     state_q <= ST_STREAM;
				ST_STREAM: begin
					if (kk_q == n_q - AW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase

			// output word valid
			priority if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					temp_q <= temperature;
					flux_q <= flux;
					n_q    <= n_clamp;
					fc_q   <= '0;
					if (!func) begin
						surf_q <= temperature;
						deep_q <= temperature;
					end
				end
			end
			ST_FILL: fc_q <= fc_q + AW'(1);
			ST_RD1:  t0_q <= rd_data;
			ST_RD2: begin
				t1_q <= rd_data;
				dt_q <= $signed({1'b0, rd_data}) - $signed({1'b0, t0_q});
			end
			ST_M2: lo_q  <= prod_q[27:0];
			ST_M3: acc_q <= prod_q[59:0];
			ST_M4: rad_q <= rad_sum[60:28];
			ST_M5: net_q <= $signed({1'b0, rad_q}) - $signed({13'b0, prod_q[36:16]});
			ST_M6: cond_q <= rnd_shift(prod_q, 24);
			ST_M7: begin
				surf_q <= new0;
				prev_q <= t0_q;
				cur_q  <= t1_q;
				kk_q   <= AW'(1);
				ra_q   <= CW'(3);
			end
			ST_STREAM: begin
				prev_q <= cur_q;
				cur_q  <= rd_data;
				cur_s1 <= cur_q;
				k_s1   <= kk_q;
				kk_q   <= kk_q + AW'(1);
				ra_q   <= ra_q + CW'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					out_surf_q <= surf_q;
					out_deep_q <= deep_q;
				end
			end
			ST_RD0, ST_M1, ST_DRAIN: ;
			default: ;
		endcase

		// last write-back is slice n-1
		if (wr_s1) begin
			deep_q <= new_k;
		end
	end

endmodule

// ===== bench/column_checker_pkg.sv =====
package column_checker_pkg;

	import ehdp_pkg::*;

	// column depth of the block at its default size
	localparam int COLUMN_DEPTH = 1024;

	// item kinds on the func port
	localparam logic FUNC_FILL = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	typedef struct {
		logic [TEMP_W-1:0] surface;
		logic [TEMP_W-1:0] deep;
	} temp_pair_t;

	// Mirrors the temperature column and checks each result word in order.
	class column_checker;
		cfg_t              cfg;
		logic [TEMP_W-1:0] column [0:COLUMN_DEPTH];
		temp_pair_t        pending_temps [$];
		int unsigned       faults;
		int unsigned       checked;

		function new();
			cfg.diff_gain     = '0;
			cfg.surf_gain     = '0;
			cfg.emis_coeff    = 32'd14357596;
			cfg.absorp        = 17'd52429;
			cfg.active_slices = 11'd1024;
			foreach (column[k]) column[k] = '0;
			faults  = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_DIFF_GAIN:  cfg.diff_gain     = value[23:0];
				REG_SURF_GAIN:  cfg.surf_gain     = value[23:0];
				REG_EMIS_COEFF: cfg.emis_coeff    = value;
				REG_ABSORP:     cfg.absorp        = value[16:0];
				REG_ACTIVE:     cfg.active_slices = value[10:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [2:0] idx);
			case (idx)
				REG_DIFF_GAIN:  return {8'd0, cfg.diff_gain};
				REG_SURF_GAIN:  return {8'd0, cfg.surf_gain};
				REG_EMIS_COEFF: return cfg.emis_coeff;
				REG_ABSORP:     return {15'd0, cfg.absorp};
				REG_ACTIVE:     return {21'd0, cfg.active_slices};
				default:        return '0;
			endcase
		endfunction

		function void compare_reg(logic [2:0] idx, logic [31:0] got);
			if (got !== reg_value(idx)) begin
				$display("%0t: register %0d read back %h, expected %h",
					$time, idx, got, reg_value(idx));
				faults++;
			end
		endfunction

		// fixed bottom slice, clamped to the column
		function int unsigned bottom();
			int unsigned n;
			n = cfg.active_slices;
			if (n < 2) n = 2;
			if (n > COLUMN_DEPTH) n = COLUMN_DEPTH;
			return n;
		endfunction

		// floor((v + 2^(s-1)) / 2^s)
		function longint round_shift(longint v, int s);
			return (v + (longint'(1) << (s - 1))) >>> s;
		endfunction

		function logic [TEMP_W-1:0] clamp_temp(longint v);
			if (v < 0) return '0;
			if (v > ((longint'(1) << TEMP_W) - 1)) return '1;
			return v[TEMP_W-1:0];
		endfunction

		// emission term ec * T^4, W/m^2 in Q.8
		function longint emitted(logic [TEMP_W-1:0] t);
			longint unsigned x, t2, t4, hi, lo, ec;
			x  = t;
			t2 = (x * x) >> 20;
			t4 = t2 * t2;
			hi = t4 >> 28;
			lo = t4 & 64'hFFF_FFFF;
			ec = cfg.emis_coeff;
			return longint'((ec * hi + ((ec * lo) >> 28)) >> 28);
		endfunction

		// fill or advance the column, queue the surface/deep pair
		function void note_item(logic f, logic [TEMP_W-1:0] t, logic [FLUX_W-1:0] fx);
			int unsigned n;
			longint g, sg, ab, fl, t0, t1, absorbed, net, prev_old, cond, rad;
			longint cur, nxt, d2;
			temp_pair_t res;
			n = bottom();
			if (f == FUNC_FILL) begin
				foreach (column[k]) column[k] = t;
			end else begin
				g        = cfg.diff_gain;
				sg       = cfg.surf_gain;
				ab       = cfg.absorp;
				fl       = fx;
				t0       = column[0];
				t1       = column[1];
				absorbed = (ab * fl) >>> 16;
				net      = emitted(column[0]) - absorbed;
				prev_old = t0;
				cond     = round_shift(2 * g * (t1 - t0), 24);
				rad      = round_shift(sg * net, 14);
				column[0] = clamp_temp(t0 + cond - rad);
				// interior slices use the old upper neighbor
				for (int k = 1; k < n; k++) begin
					cur = column[k];
					nxt = column[k + 1];
					d2  = nxt - 2 * cur + prev_old;
					column[k] = clamp_temp(cur + round_shift(g * d2, 24));
					prev_old = cur;
				end
			end
			res.surface = column[0];
			res.deep    = column[n - 1];
			pending_temps = {pending_temps, res};
		endfunction

		function void check_result(logic [TEMP_W-1:0] surface, logic [TEMP_W-1:0] deep);
			temp_pair_t want;
			if (pending_temps.size() == 0) begin
				$display("%0t: result word with nothing pending: surface %h deep %h",
					$time, surface, deep);
				faults++;
				return;
			end
			want = pending_temps.pop_front();
			checked++;
			if (surface !== want.surface) begin
				$display("%0t: surface_temp expected %h, got %h", $time, want.surface, surface);
				faults++;
			end
			if (deep !== want.deep) begin
				$display("%0t: deep_temp expected %h, got %h", $time, want.deep, deep);
				faults++;
			end
		endfunction

		function int outstanding();
			return pending_temps.size();
		endfunction
	endclass

endpackage

// ===== bench/tb_explicit_heat_diffusion_profile.sv =====
module tb_explicit_heat_diffusion_profile;

	timeunit 1ns;
	timeprecision 1ps;

	import ehdp_pkg::*;
	import column_checker_pkg::*;

	localparam int          CLK_HALF     = 2;
	localparam int          RESET_CYCLES = 12;
	localparam int unsigned ITEMS_TOTAL  = 580;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          TAIL_CYCLES  = 1100;
	localparam int unsigned LIMIT_CYCLES = 2_500_000;

	// address past the last register
	localparam logic [2:0] REG_UNUSED = 3'd5;

	// settings families for the random phases
	localparam int SET_TYPICAL = 0;
	localparam int SET_EXTREME = 1;
	localparam int SET_DEEP    = 2;

	// receiver stall patterns
	localparam int RX_STEADY  = 0;
	localparam int RX_SCATTER = 1;
	localparam int RX_RUNS    = 2;

	// temperatures and fluxes in the block's fixed point
	localparam logic [TEMP_W-1:0] T_200K     = 24'd3276800;
	localparam logic [TEMP_W-1:0] T_250K     = 24'd4096000;
	localparam logic [TEMP_W-1:0] T_300K     = 24'd4915200;
	localparam logic [FLUX_W-1:0] FLUX_SOLAR = 20'd348416;
	localparam logic [31:0]       EC_DEFAULT = 32'd14357596;
	localparam logic [16:0]       AB_DEFAULT = 17'd52429;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  item_valid;
	logic                  item_stall;
	logic                  func;
	logic [TEMP_W-1:0]     temperature;
	logic [FLUX_W-1:0]     flux;
	logic                  result_valid;
	logic                  result_stall;
	logic [TEMP_W-1:0]     surface_temp;
	logic [TEMP_W-1:0]     deep_temp;

	column_checker sb;

	bit          tx_bursty;
	int unsigned burst_left;
	int unsigned n_items;
	int unsigned n_fills;
	int unsigned n_steps;
	int unsigned n_settings;
	int unsigned hold_reqs = 0;
	int unsigned hold_served;
	int          rx_mode;
	int unsigned rx_span;
	int unsigned rx_run;
	bit          rx_level;
	int unsigned cycles;

	explicit_heat_diffusion_profile dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.temperature  (temperature),
		.flux         (flux),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.surface_temp (surface_temp),
		.deep_temp    (deep_temp)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// result word monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check_result(surface_temp, deep_temp);
	end

	// receiver: picks a new stall pattern after each random span, long hold on request
	initial begin
		result_stall = 1'b0;
		hold_served  = 0;
		rx_run       = 0;
		rx_level     = 1'b0;
		forever begin
			rx_mode = int'($urandom_range(RX_RUNS, RX_STEADY));
			rx_span = $urandom_range(512, 64);
			repeat (rx_span) begin
				@(negedge clk);
				if (hold_served != hold_reqs) begin
					hold_served++;
					result_stall <= 1'b1;
					repeat (HOLD_CYCLES - 1) @(negedge clk);
				end else if (rx_mode == RX_STEADY) begin
					result_stall <= 1'b0;
				end else if (rx_mode == RX_SCATTER) begin
					result_stall <= ($urandom_range(3, 0) == 0);
				end else begin
					if (rx_run == 0) begin
						rx_level = !rx_level;
						rx_run   = rx_level ? $urandom_range(40, 1) : $urandom_range(24, 1);
					end
					rx_run--;
					result_stall <= rx_level;
				end
			end
		end
	end

	// one APB transfer, setup then access
	task automatic apb_xfer(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
			input logic [31:0] data, output logic [31:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// write a register, then read it back
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] rd;
		apb_xfer(1'b1, {idx, 2'b00}, value, rd);
		sb.set_reg(idx, value);
		apb_xfer(1'b0, {idx, 2'b00}, '0, rd);
		sb.compare_reg(idx, rd);
	endtask

	task automatic wait_drain();
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// settings change only with the column idle
	task automatic apply_settings(input logic [23:0] dg, input logic [23:0] sg,
			input logic [31:0] ec, input logic [16:0] ab, input logic [10:0] n);
		@(negedge clk);
		item_valid <= 1'b0;
		wait_drain();
		reg_write(REG_DIFF_GAIN, {8'd0, dg});
		reg_write(REG_SURF_GAIN, {8'd0, sg});
		reg_write(REG_EMIS_COEFF, ec);
		reg_write(REG_ABSORP, {15'd0, ab});
		reg_write(REG_ACTIVE, {21'd0, n});
		n_settings++;
	endtask

	// offer one word, with a random gap ahead of each burst when tx_bursty is set
	task automatic send_item(input logic f, input logic [TEMP_W-1:0] t,
			input logic [FLUX_W-1:0] fx);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(12, 1);
			if (tx_bursty) gap = $urandom_range(10, 1);
		end
		@(negedge clk);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid  <= 1'b1;
		func        <= f;
		temperature <= t;
		flux        <= fx;
		do @(posedge clk); while (item_stall);
		sb.note_item(f, t, fx);
		burst_left--;
		n_items++;
		if (f == FUNC_FILL) n_fills++;
		else n_steps++;
	endtask

	// mostly steps; temperatures and fluxes either plausible or any bit pattern
	task automatic random_item();
		logic [TEMP_W-1:0] t;
		logic [FLUX_W-1:0] fx;
		t  = $urandom_range(1, 0) ? TEMP_W'($urandom_range(6553600, 1638400))
			: TEMP_W'($urandom);
		fx = $urandom_range(1, 0) ? FLUX_W'($urandom_range(358400, 0)) : FLUX_W'($urandom);
		if ($urandom_range(7, 0) == 0) send_item(FUNC_FILL, t, fx);
		else send_item(FUNC_STEP, t, fx);
	endtask

	task automatic random_settings(input int kind);
		logic [23:0] dg, sg;
		logic [31:0] ec;
		logic [16:0] ab;
		logic [10:0] n;
		dg = 24'($urandom_range(24'h800000, 0));
		sg = 24'($urandom_range(8192, 0));
		ec = $urandom_range(15000000, 13000000);
		ab = 17'($urandom_range(65536, 40000));
		n  = 11'($urandom_range(48, 2));
		case (kind)
			SET_DEEP: begin
				n = $urandom_range(1, 0) ? 11'd1024 : 11'($urandom_range(2047, 1025));
			end
			SET_EXTREME: begin
				case ($urandom_range(3, 0))
					0: dg = '0;
					1: dg = 24'h800000;
					2: dg = '1;
					default: dg = 24'($urandom);
				endcase
				case ($urandom_range(2, 0))
					0: sg = '0;
					1: sg = '1;
					default: sg = 24'($urandom);
				endcase
				case ($urandom_range(2, 0))
					0: ec = '0;
					1: ec = '1;
					default: ec = $urandom;
				endcase
				case ($urandom_range(3, 0))
					0: ab = '0;
					1: ab = 17'h10000;
					2: ab = '1;
					default: ab = 17'($urandom);
				endcase
				if ($urandom_range(1, 0) != 0) n = 11'($urandom_range(3, 0));
			end
			default: ;
		endcase
		apply_settings(dg, sg, ec, ab, n);
	endtask

	initial begin
		int          kind;
		int unsigned count;
		logic [31:0] rd;

		sb          = new();
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		item_valid  = 1'b0;
		func        = FUNC_FILL;
		temperature = '0;
		flux        = '0;
		tx_bursty   = 1'b1;
		burst_left  = 0;
		n_items     = 0;
		n_fills     = 0;
		n_steps     = 0;
		n_settings  = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: short column, gain at one half
		apply_settings(24'h800000, 24'h001000, EC_DEFAULT, AB_DEFAULT, 11'd4);
		send_item(FUNC_FILL, '0, '0);
		send_item(FUNC_STEP, '0, '0);
		send_item(FUNC_STEP, '0, '1);
		send_item(FUNC_FILL, '1, '0);
		send_item(FUNC_STEP, '0, '0);
		send_item(FUNC_STEP, '0, '1);
		send_item(FUNC_FILL, T_300K, '0);
		send_item(FUNC_STEP, '0, FLUX_SOLAR);
		// unused fields carry junk
		send_item(FUNC_STEP, '1, '0);
		send_item(FUNC_FILL, 24'h555555, 20'hAAAAA);
		send_item(FUNC_STEP, 24'hAAAAAA, 20'h55555);

		// bottom index below range, unstable gain, absorptance above one
		apply_settings('1, '1, '1, '1, 11'd0);
		send_item(FUNC_FILL, 24'hAAAAAA, '0);
		send_item(FUNC_STEP, '0, '1);
		send_item(FUNC_STEP, '0, '0);

		// everything off; a write past the register list must change nothing
		apply_settings('0, '0, '0, '0, 11'd1);
		apb_xfer(1'b1, {REG_UNUSED, 2'b00}, $urandom, rd);
		send_item(FUNC_FILL, T_200K, '0);
		send_item(FUNC_STEP, '0, '1);

		// bottom index above range, full column
		apply_settings(24'd3355443, 24'd2000, EC_DEFAULT, 17'h10000, 11'h7FF);
		send_item(FUNC_FILL, T_250K, '0);
		send_item(FUNC_STEP, '0, 20'h3F000);
		send_item(FUNC_STEP, '0, FLUX_SOLAR);

		// smallest column, smallest gains
		apply_settings(24'd1, 24'd1, EC_DEFAULT, AB_DEFAULT, 11'd2);
		send_item(FUNC_FILL, T_300K, '0);
		send_item(FUNC_STEP, '0, FLUX_SOLAR);

		// back-pressure: receiver holds while the sender keeps offering
		apply_settings(24'd3355443, 24'd2000, EC_DEFAULT, AB_DEFAULT, 11'd6);
		tx_bursty = 1'b0;
		hold_reqs++;
		repeat (30) random_item();

		// random phases
		while (n_items < ITEMS_TOTAL) begin
			case ($urandom_range(9, 0))
				0:       kind = SET_DEEP;
				1, 2:    kind = SET_EXTREME;
				default: kind = SET_TYPICAL;
			endcase
			random_settings(kind);
			tx_bursty = ($urandom_range(2, 0) != 0);
			count = (kind == SET_DEEP) ? $urandom_range(8, 3) : $urandom_range(50, 20);
			repeat (count) begin
				if (n_items < ITEMS_TOTAL) random_item();
			end
		end

		@(negedge clk);
		item_valid <= 1'b0;
		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d words (%0d fills, %0d steps) under %0d register settings,",
			n_items, n_fills, n_steps, n_settings);
		$display("%0d result words checked, %0d mismatches", sb.checked, sb.faults);
		if (sb.faults == 0 && sb.outstanding() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ehdp_pkg.sv
rtl/core/ehdp_ram.sv
rtl/core/ehdp_regs.sv
rtl/core/explicit_heat_diffusion_profile.sv
bench/column_checker_pkg.sv
bench/tb_explicit_heat_diffusion_profile.sv
